### design/fat_pkg.sv
// Shared types and constants for the allocation table chain engine.
// Holds the transaction structs and the controller/datapath command and status groups.
// Depends on nothing; every other design file but fat_ram imports it.
package fat_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 12;
    localparam int BYTES_W = 24;
    localparam int BASE_W  = 16;
    localparam int ENTRY_W = IDX_W + 1;   // in-use flag over the link

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int BLOCK_BYTES_DEF   = 4096;

    localparam logic [BASE_W-1:0] DATA_BASE_RESET = 16'd4096;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_FREE   = 2'd1,
        OP_SEEK   = 2'd2,
        OP_TRUNC  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                opcode;
        logic [IDX_W-1:0]   chain_index;
        logic               chain_empty;
        logic [BYTES_W-1:0] byte_offset;
    } fat_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  result_index;
        logic [BASE_W-1:0] data_block;
        logic              status;
    } fat_rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new transaction
        logic clr_step;   // clear one table entry after reset
        logic rd_hint;    // read the entry at the free pointer
        logic hint_inc;   // advance the free pointer
        logic wr_tail;    // link the tail to the new entry
        logic wr_found;   // mark the new entry as a chain end
        logic rd_cur;     // read the entry at the walk pointer
        logic step;       // follow one link during a walk
        logic free_ent;   // release the current entry and follow its link
        logic cut;        // make the current entry a chain end
        logic set_res;    // result index from the walk pointer
        logic set_full;   // no free entry
        logic set_noblk;  // result carries no block
        logic out_load;   // move the result into the output register
    } fat_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic in_range;
        logic append_link;
        logic clr_last;
        logic hint_full;
        logic walk_more;
        logic cnt_full;
        logic rd_used;
        logic nx_is_cur;
        logic out_free;
    } fat_stat_t;

endpackage

### design/fat_chain_table_engine.sv
// Top level of the allocation table chain engine: controller plus datapath.
// Depends on fat_pkg, fat_ctrl, fat_datapath (which holds fat_ram).
//
// req (req_valid/req_ready): one operation per transaction: append, free chain,
//   seek or truncate. rsp (rsp_valid/rsp_ready): one result per request, in order.
//   cfg_wr_en/cfg_wr_data write data_base, added to result_index for data_block.
// One operation runs at a time; each table read is a read step, then an evaluate step.
// Append scans used entries upward from the lowest-free pointer; free releases
// the entries of the chain; seek follows links; truncate follows links, then
// releases the entries behind the kept one. A walk stops at a chain end, a
// release at a free entry. A full table answers an append with status full; a
// free, seek or truncate whose head lies beyond the table answers without a walk.
// The next request can be taken once a result enters the output register,
// even while it waits for rsp_ready; a later result then waits inside.
// Reset: data_base returns to 4096 and a clearing pass goes over the whole
// table, one entry per cycle, with req_ready low. Configuration writes are taken
// at any time.
module fat_chain_table_engine import fat_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  fat_req_t          req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fat_rsp_t          rsp,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data
);

    fat_cmd_t  cmd;
    fat_stat_t stat;

    // Sequencer
    fat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, pointers and output register
    fat_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BLOCK_BYTES   (BLOCK_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

### design/fat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/fat_datapath.sv
// Datapath: link table memory, walk and free pointers, counters, result and output register.
// Depends on fat_pkg and fat_ram; driven by fat_ctrl through fat_cmd_t.
module fat_datapath import fat_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fat_req_t          req,
    input  fat_cmd_t          cmd,
    output fat_stat_t         stat,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fat_rsp_t          rsp
);

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int CW     = $clog2(TABLE_ENTRIES + 1);
    localparam int IDXE_W = IDX_W + 1;
    localparam logic [CW-1:0]      CNT_MAX  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0]      CNT_LAST = CW'(TABLE_ENTRIES - 1);
    localparam logic [IDXE_W-1:0]  IDX_LIM  = IDXE_W'(TABLE_ENTRIES);
    localparam logic [BYTES_W-1:0] BLK_B    = BYTES_W'(BLOCK_BYTES);

    // Transaction and walk registers
    op_t                op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               empty_reg;
    logic [BYTES_W-1:0] rem_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   res_reg;
    logic               status_reg;
    logic               blk_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      hint_reg;   // every entry below it is in use
    logic [BASE_W-1:0]  base_reg;
    logic               rsp_valid_reg;
    fat_rsp_t           rsp_reg;

    // Memory port signals
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               rd_used;
    logic [IDX_W-1:0]   rd_link;
    logic               link_ok;
    logic [IDX_W-1:0]   nx;
    logic               out_free;

    fat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next entry of the one just read; itself when free, self linked or linked off the table
    assign rd_used = ram_rdata[ENTRY_W-1];
    assign rd_link = ram_rdata[IDX_W-1:0];
    assign link_ok = (IDXE_W'(rd_link) < IDX_LIM);
    assign nx      = (rd_used && link_ok) ? rd_link : cur_reg;

    // Memory write and read selection
    always_comb
    begin
        ram_we    = cmd.clr_step | cmd.wr_tail | cmd.wr_found | cmd.free_ent | cmd.cut;
        ram_waddr = cur_reg[AW-1:0];
        ram_wdata = '0;
        if (cmd.clr_step)
        begin
            ram_waddr = cnt_reg[AW-1:0];
        end
        else if (cmd.wr_tail)
        begin
            ram_waddr = idx_reg[AW-1:0];
            ram_wdata = {1'b1, IDX_W'(hint_reg)};
        end
        else if (cmd.wr_found)
        begin
            ram_waddr = hint_reg[AW-1:0];
            ram_wdata = {1'b1, IDX_W'(hint_reg)};
        end
        else if (cmd.cut)
        begin
            ram_wdata = {1'b1, cur_reg};
        end
        ram_re    = cmd.rd_hint | cmd.rd_cur;
        ram_raddr = cmd.rd_hint ? hint_reg[AW-1:0] : cur_reg[AW-1:0];
    end

    assign out_free = !rsp_valid_reg || rsp_ready;

    // Status toward the controller
    always_comb
    begin
        stat.op          = op_reg;
        stat.in_range    = (IDXE_W'(idx_reg) < IDX_LIM);
        stat.append_link = !empty_reg;
        stat.clr_last    = (cnt_reg == CNT_LAST);
        stat.hint_full   = (hint_reg == CNT_MAX);
        stat.walk_more   = (cnt_reg != CNT_MAX) && (rem_reg >= BLK_B);
        stat.cnt_full    = (cnt_reg == CNT_MAX);
        stat.rd_used     = rd_used;
        stat.nx_is_cur   = (nx == cur_reg);
        stat.out_free    = out_free;
    end

    // Control counters and the free pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            hint_reg <= '0;
        end
        else
        begin
            if (cmd.load || cmd.cut)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clr_step || cmd.step || cmd.free_ent)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end

            if (cmd.hint_inc)
            begin
                hint_reg <= hint_reg + CW'(1);
            end
            else if (cmd.free_ent && (CW'(cur_reg) < hint_reg))
            begin
                hint_reg <= CW'(cur_reg);
            end
        end
    end

    // Transaction payload and walk state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req.opcode;
            idx_reg    <= req.chain_index;
            empty_reg  <= req.chain_empty;
            cur_reg    <= req.chain_index;
            status_reg <= STATUS_DONE;
            blk_reg    <= 1'b1;
            // truncate keeps the block that holds the last byte
            if (req.opcode == OP_TRUNC && req.byte_offset != '0)
            begin
                rem_reg <= req.byte_offset - BYTES_W'(1);
            end
            else if (req.opcode == OP_TRUNC)
            begin
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= req.byte_offset;
            end
        end
        else
        begin
            if (cmd.step)
            begin
                rem_reg <= rem_reg - BLK_B;
            end
            if (cmd.step || cmd.free_ent || cmd.cut)
            begin
                cur_reg <= nx;
            end
            if (cmd.set_res)
            begin
                res_reg <= cur_reg;
            end
            else if (cmd.wr_found)
            begin
                res_reg <= IDX_W'(hint_reg);
            end
            if (cmd.set_full)
            begin
                status_reg <= STATUS_FULL;
                blk_reg    <= 1'b0;
            end
            else if (cmd.set_noblk)
            begin
                blk_reg <= 1'b0;
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= DATA_BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.status <= status_reg;
            if (blk_reg)
            begin
                rsp_reg.result_index <= res_reg;
                rsp_reg.data_block   <= BASE_W'(res_reg) + base_reg;
            end
            else
            begin
                rsp_reg.result_index <= '0;
                rsp_reg.data_block   <= '0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= CNT_MAX)
        else $error("free pointer beyond table");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("link counter beyond table");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table read and write in the same cycle");

    a_out_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("result overwrites a pending transaction");

    a_free_pointer_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_found |=> (hint_reg == $past(hint_reg) + CW'(1)))
        else $error("free pointer not advanced after allocation");

endmodule

### design/fat_ctrl.sv
// Controller: sequences the clearing pass and each operation over the datapath.
// Depends on fat_pkg; drives fat_datapath through fat_cmd_t, watches fat_stat_t.
module fat_ctrl import fat_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  fat_stat_t stat,
    output fat_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_CLEAR    = 13'b0000000000001,
        S_IDLE     = 13'b0000000000010,
        S_DISPATCH = 13'b0000000000100,
        S_ALLOC_RD = 13'b0000000001000,
        S_ALLOC_EV = 13'b0000000010000,
        S_APP_SELF = 13'b0000000100000,
        S_WALK_RD  = 13'b0000001000000,
        S_WALK_EV  = 13'b0000010000000,
        S_TRUNC_RD = 13'b0000100000000,
        S_TRUNC_EV = 13'b0001000000000,
        S_FREE_RD  = 13'b0010000000000,
        S_FREE_EV  = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_APPEND:
                    begin
                        state_next = S_ALLOC_RD;
                    end
                    OP_FREE:
                    begin
                        cmd.set_noblk = 1'b1;
                        state_next    = stat.in_range ? S_FREE_RD : S_DONE;
                    end
                    default:
                    begin
                        // seek and truncate
                        if (stat.in_range)
                        begin
                            state_next = S_WALK_RD;
                        end
                        else
                        begin
                            cmd.set_res = 1'b1;
                            state_next  = S_DONE;
                        end
                    end
                endcase
            end
            S_ALLOC_RD:
            begin
                if (stat.hint_full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_hint = 1'b1;
                    state_next  = S_ALLOC_EV;
                end
            end
            S_ALLOC_EV:
            begin
                if (stat.rd_used)
                begin
                    cmd.hint_inc = 1'b1;
                    state_next   = S_ALLOC_RD;
                end
                else
                begin
                    cmd.wr_tail = stat.append_link && stat.in_range;
                    state_next  = S_APP_SELF;
                end
            end
            S_APP_SELF:
            begin
                cmd.wr_found = 1'b1;
                cmd.hint_inc = 1'b1;
                state_next   = S_DONE;
            end
            S_WALK_RD:
            begin
                if (stat.walk_more)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_WALK_EV;
                end
                else if (stat.op == OP_SEEK)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_TRUNC_RD;
                end
            end
            S_WALK_EV:
            begin
                if (!stat.nx_is_cur)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_WALK_RD;
                end
                else if (stat.op == OP_SEEK)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_TRUNC_RD;
                end
            end
            S_TRUNC_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_TRUNC_EV;
            end
            S_TRUNC_EV:
            begin
                cmd.set_res = 1'b1;
                state_next  = S_DONE;
                if (stat.rd_used)
                begin
                    cmd.cut = 1'b1;
                    if (!stat.nx_is_cur)
                    begin
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_FREE_RD:
            begin
                if (stat.cnt_full)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_FREE_EV;
                end
            end
            S_FREE_EV:
            begin
                if (!stat.rd_used)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.free_ent = 1'b1;
                    state_next   = stat.nx_is_cur ? S_DONE : S_FREE_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for fat_chain_table_engine: directed and random phases.
// Predicts each response from its own copy of the link table; depends on fat_pkg and the RTL.

module tb_top;
    import fat_pkg::*;

    localparam int unsigned TBL_N       = TABLE_ENTRIES_DEF;
    localparam int unsigned BLK_BYTES   = BLOCK_BYTES_DEF;
    localparam int          SCORE       = 0;    // table copy that follows accepted transactions
    localparam int          PLAN        = 1;    // table copy the generator runs ahead on
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned BASE_TOP    = 61439;
    localparam int          MAX_PRINTS  = 40;
    localparam int          MAX_FILES   = 8;
    localparam int unsigned MAX_BLOCKS  = 48;
    localparam int          DRAIN_CYC   = 64;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_ready;
    fat_req_t          req         = '0;
    logic              rsp_valid;
    logic              rsp_ready   = 1'b0;
    fat_rsp_t          rsp;
    logic              cfg_wr_en   = 1'b0;
    logic [BASE_W-1:0] cfg_wr_data = '0;

    // model state: two copies of the table and of data_base
    logic [ENTRY_W-1:0] link_mem [2][TBL_N];
    logic [BASE_W-1:0]  base_mem [2];

    fat_req_t    req_backlog[$];    // requests waiting for the driver
    fat_rsp_t    rsp_due[$];        // predicted responses, oldest first
    int unsigned file_heads[$];     // heads of the files the generator keeps alive

    logic        req_taken     = 1'b0;
    int          send_gap      = 0;
    int          rsp_stall     = 0;
    int          send_idle_pct = 0;
    int          rsp_idle_pct  = 0;
    logic        calm          = 1'b0;
    int          err_count     = 0;
    int unsigned cycle_cnt     = 0;

    fat_chain_table_engine #(
        .TABLE_ENTRIES (TBL_N),
        .BLOCK_BYTES   (BLK_BYTES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- table model

    function automatic logic entry_used(input int cp, input int unsigned ix);
        return (ix < TBL_N) && link_mem[cp][ix][IDX_W];
    endfunction

    // next entry, or ix itself at a chain end or a free entry
    function automatic int unsigned next_entry(input int cp, input int unsigned ix);
        int unsigned nx;
        if (!entry_used(cp, ix))
            return ix;
        nx = 32'(link_mem[cp][ix][IDX_W-1:0]);
        return (nx >= TBL_N) ? ix : nx;
    endfunction

    function automatic void release_chain(input int cp, input int unsigned start);
        int unsigned cur;
        int unsigned nx;
        int unsigned n;
        cur = start;
        n   = 0;
        while (n < TBL_N && entry_used(cp, cur))
        begin
            nx = next_entry(cp, cur);
            link_mem[cp][cur] = '0;
            n   = (nx == cur) ? TBL_N : n + 1;
            cur = nx;
        end
    endfunction

    function automatic int unsigned walk_links(input int cp, input int unsigned head,
                                               input int unsigned steps);
        int unsigned cur;
        int unsigned nx;
        int unsigned n;
        cur = head;
        n   = 0;
        nx  = next_entry(cp, cur);
        while (n < steps && n < TBL_N && nx != cur)
        begin
            cur = nx;
            nx  = next_entry(cp, cur);
            n++;
        end
        return cur;
    endfunction

    // runs one transaction against a table copy and returns its response
    function automatic fat_rsp_t apply_fat_op(input int cp, input fat_req_t r);
        fat_rsp_t    o;
        int unsigned ix;
        int unsigned bytes;
        int unsigned cur;
        int unsigned nx;
        int unsigned steps;
        logic        has_block;
        ix        = 32'(r.chain_index);
        bytes     = 32'(r.byte_offset);
        cur       = 0;
        has_block = 1'b1;
        o         = '0;
        o.status  = STATUS_DONE;
        case (r.opcode)
            OP_APPEND:
            begin
                // lowest free entry
                while (cur < TBL_N && link_mem[cp][cur][IDX_W])
                    cur++;
                if (cur == TBL_N)
                begin
                    o.status  = STATUS_FULL;
                    has_block = 1'b0;
                end
                else
                begin
                    if (!r.chain_empty && ix < TBL_N)
                        link_mem[cp][ix] = {1'b1, cur[IDX_W-1:0]};
                    link_mem[cp][cur] = {1'b1, cur[IDX_W-1:0]};
                end
            end
            OP_FREE:
            begin
                if (ix < TBL_N)
                    release_chain(cp, ix);
                has_block = 1'b0;
            end
            OP_SEEK:
            begin
                cur = (ix < TBL_N) ? walk_links(cp, ix, bytes / BLK_BYTES) : ix;
            end
            default:
            begin
                // truncate: keep the block holding the last byte, release the rest
                if (ix < TBL_N)
                begin
                    steps = (bytes == 0) ? 0 : (bytes - 1) / BLK_BYTES;
                    cur   = walk_links(cp, ix, steps);
                    if (entry_used(cp, cur))
                    begin
                        nx = next_entry(cp, cur);
                        link_mem[cp][cur] = {1'b1, cur[IDX_W-1:0]};
                        if (nx != cur)
                            release_chain(cp, nx);
                    end
                end
                else
                    cur = ix;
            end
        endcase
        if (has_block)
        begin
            o.result_index = cur[IDX_W-1:0];
            o.data_block   = cur[BASE_W-1:0] + base_mem[cp];
        end
        return o;
    endfunction

    function automatic int unsigned chain_blocks(input int unsigned head);
        int unsigned cur;
        int unsigned nx;
        int unsigned n;
        cur = head;
        n   = 1;
        nx  = next_entry(PLAN, cur);
        while (nx != cur && n < TBL_N)
        begin
            cur = nx;
            nx  = next_entry(PLAN, cur);
            n++;
        end
        return n;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // queues one request and runs it on the look-ahead table
    function automatic fat_rsp_t issue(input op_t op, input int unsigned ix, input logic empty,
                                       input int unsigned offset);
        fat_req_t r;
        r.opcode      = op;
        r.chain_index = ix[IDX_W-1:0];
        r.chain_empty = empty;
        r.byte_offset = offset[BYTES_W-1:0];
        req_backlog.push_back(r);
        return apply_fat_op(PLAN, r);
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    // checks at rising edges, where driver outputs are settled; returns at a falling edge
    task automatic wait_drained();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
        @(negedge clk);
    endtask

    task automatic set_data_base(input int unsigned v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[BASE_W-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        base_mem[SCORE] = v[BASE_W-1:0];
        base_mem[PLAN]  = v[BASE_W-1:0];
    endtask

    // empty table in, empty table out
    task automatic directed_items();
        // free entries as heads
        void'(issue(OP_SEEK,   0,    1'b0, 0));
        void'(issue(OP_TRUNC,  4095, 1'b1, 24'hFFFFFF));
        void'(issue(OP_FREE,   7,    1'b1, 24'hFFFFFF));
        // build chain 0-1-2-3
        void'(issue(OP_APPEND, 4095, 1'b1, 0));
        void'(issue(OP_APPEND, 0,    1'b0, 0));
        void'(issue(OP_APPEND, 1,    1'b0, 24'hFFFFFF));
        void'(issue(OP_APPEND, 2,    1'b0, 0));
        // seeks around block borders and past the end
        void'(issue(OP_SEEK,   0,    1'b0, 4095));
        void'(issue(OP_SEEK,   0,    1'b0, 4096));
        void'(issue(OP_SEEK,   0,    1'b0, 12288));
        void'(issue(OP_SEEK,   0,    1'b0, 24'hFFFFFF));
        // truncate mid-chain, then to zero length
        void'(issue(OP_TRUNC,  0,    1'b0, 8193));
        void'(issue(OP_TRUNC,  0,    1'b0, 0));
        // append twice on the same tail: second one overwrites the link
        void'(issue(OP_APPEND, 0,    1'b0, 0));
        void'(issue(OP_APPEND, 0,    1'b0, 0));
        void'(issue(OP_FREE,   0,    1'b0, 0));
        void'(issue(OP_SEEK,   1,    1'b0, 4096));
        void'(issue(OP_FREE,   1,    1'b0, 0));
        // append onto a free tail: the tail turns in use
        void'(issue(OP_APPEND, 4095, 1'b0, 0));
        void'(issue(OP_SEEK,   4095, 1'b0, 4096));
        void'(issue(OP_FREE,   4095, 1'b0, 0));
    endtask

    // mostly well-formed file traffic, some raw noise
    task automatic random_phase(input int n_items);
        int unsigned head;
        int unsigned len;
        int unsigned roll;
        int unsigned off;
        int          k;
        int          i;
        fat_rsp_t    got;
        repeat (n_items)
        begin
            // forget files whose head was released by a stray transaction
            for (i = file_heads.size() - 1; i >= 0; i--)
                if (!entry_used(PLAN, file_heads[i]))
                    file_heads.delete(i);
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                void'(issue(op_t'($urandom_range(3)), $urandom_range(TBL_N - 1),
                            $urandom_range(1) != 0, $urandom_range(24'hFFFFFF)));
            end
            else if (file_heads.size() == 0 || (roll < 30 && file_heads.size() < MAX_FILES))
            begin
                got = issue(OP_APPEND, $urandom_range(TBL_N - 1), 1'b1,
                            $urandom_range(24'hFFFFFF));
                if (got.status == STATUS_DONE)
                    file_heads.push_back(32'(got.result_index));
            end
            else
            begin
                k    = $urandom_range(file_heads.size() - 1);
                head = file_heads[k];
                len  = chain_blocks(head);
                roll = $urandom_range(99);
                if (roll < 40 && len < MAX_BLOCKS)
                    void'(issue(OP_APPEND, walk_links(PLAN, head, TBL_N), 1'b0,
                                $urandom_range(24'hFFFFFF)));
                else if (roll < 65)
                    void'(issue(OP_SEEK, head, $urandom_range(1) != 0,
                                $urandom_range((len + 1) * BLK_BYTES)));
                else if (roll < 92)
                begin
                    off = ($urandom_range(3) == 0) ? 0 : $urandom_range(len * BLK_BYTES);
                    void'(issue(OP_TRUNC, head, $urandom_range(1) != 0, off));
                end
                else
                begin
                    void'(issue(OP_FREE, head, $urandom_range(1) != 0,
                                $urandom_range(24'hFFFFFF)));
                    file_heads.delete(k);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- driver

    // request side: next transaction once the slot frees up, random gaps in between
    always @(negedge clk)
    begin
        if (!req_valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (req_backlog.size() > 0)
            begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
                if (!calm && $urandom_range(99) < send_idle_pct)
                    send_gap <= $urandom_range(12, 1);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response side: ready with random stall bursts
    always @(negedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(99) < rsp_idle_pct)
                rsp_stall <= $urandom_range(12, 1);
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin : scoreboard
        fat_rsp_t want;
        req_taken <= req_valid && req_ready;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_due.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = rsp_due.pop_front();
                if (rsp.result_index !== want.result_index)
                    report_mismatch($sformatf("result_index got %0d want %0d",
                                              rsp.result_index, want.result_index));
                if (rsp.data_block !== want.data_block)
                    report_mismatch($sformatf("data_block got %0d want %0d",
                                              rsp.data_block, want.data_block));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0b want %0b",
                                              rsp.status, want.status));
            end
        end
        if (rst_n && req_valid && req_ready)
            rsp_due.push_back(apply_fat_op(SCORE, req));
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d responses outstanding",
                     cycle_cnt, rsp_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- test sequence

    initial
    begin : stimulus
        int unsigned i;
        for (i = 0; i < TBL_N; i++)
        begin
            link_mem[SCORE][i] = '0;
            link_mem[PLAN][i]  = '0;
        end
        base_mem[SCORE] = DATA_BASE_RESET;
        base_mem[PLAN]  = DATA_BASE_RESET;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed cases with data_base at its reset value
        send_idle_pct = 20;
        rsp_idle_pct  = 20;
        @(posedge clk);
        directed_items();
        wait_drained();

        set_data_base(0);
        send_idle_pct = 40;
        rsp_idle_pct  = 40;
        @(posedge clk);
        random_phase(300);
        wait_drained();

        set_data_base($urandom_range(BASE_TOP));
        send_idle_pct = 15;
        rsp_idle_pct  = 30;
        @(posedge clk);
        random_phase(300);
        wait_drained();

        // last stretch runs back to back on both sides
        set_data_base($urandom_range(BASE_TOP));
        calm = 1'b1;
        @(posedge clk);
        random_phase(350);
        wait_drained();

        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
design/fat_pkg.sv
design/fat_ram.sv
design/fat_datapath.sv
design/fat_ctrl.sv
design/fat_chain_table_engine.sv
tb/sv/tb_top.sv
